### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Operation codes, status codes and fixed field widths used by the engine
// and its port checker.
// ----------------------------------------------------------------------------
package ple_pkg;

	// Fixed widths of the item fields.
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int DATA_W = 32;

	// Operation codes carried by func.
	localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT_AT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

endpackage

### rtl/core/ple_mem.sv
// ----------------------------------------------------------------------------
// ple_mem: element store of the positional list engine
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ple_mem
	import ple_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/positional_list_engine_top.sv
// An item that fails its checks goes from acceptance straight to the finish state and the output register.
// An insert below the count shifts the tail up before writing the new element; an append writes it directly.
// A delete shifts the tail down over the removed slot, also for the last element, and an item's result
// can wait further while the result side stalls.
// The store moves one element per cycle through its read and write ports.
// Throughput: one item at a time; req_stall is high from acceptance to the result.
// ----------------------------------------------------------------------------
// positional_list_engine_top: bounded ordered list with positional edits
// Adds, inserts and deletes signed 32-bit elements at the front, the back
// or a given slot, shifting the tail through a shared element store.
// Reset (arst_n low) empties the list; the element store itself is not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_top
	import ple_pkg::*;
#(
	parameter int CAPACITY = 16,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	input  logic [CNT_W-1:0]         position,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [STAT_W-1:0]        status,
	output logic [CNT_W-1:0]         count,
	output logic signed [DATA_W-1:0] removed_value,
	output logic signed [DATA_W-1:0] first_value,
	output logic signed [DATA_W-1:0] last_value
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PUT,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_GRAB,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [IDX_W-1:0]    stop_q;
	logic [IDX_W-1:0]    slot_q;
	logic                is_ins_q;
	logic [DATA_W-1:0]   value_q;
	logic [CNT_W-1:0]    count_q;
	logic [STAT_W-1:0]   status_q;
	logic [DATA_W-1:0]   removed_q;
	logic [DATA_W-1:0]   first_q;
	logic [DATA_W-1:0]   last_q;
	logic                wr_pend_s1;
	logic [IDX_W-1:0]    wr_addr_s1;
	logic                cap_s1;
	logic                rsp_valid_q;
	logic [STAT_W-1:0]   status_q2_q;
	logic [CNT_W-1:0]    count_out_q;
	logic [DATA_W-1:0]   removed_out_q;
	logic [DATA_W-1:0]   first_out_q;
	logic [DATA_W-1:0]   last_out_q;

	logic                accept;
	logic                is_ins;
	logic                is_del;
	logic [CNT_W-1:0]    ins_slot;
	logic [CNT_W-1:0]    del_slot;
	logic [STAT_W-1:0]   dec_status;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [DATA_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [IDX_W-1:0]    mem_raddr;
	logic [DATA_W-1:0]   mem_rdata;
	logic                rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Decode the operation into a target slot and check it against the list.
	always_comb begin
		is_ins   = 1'b0;
		is_del   = 1'b0;
		ins_slot = count_q;
		del_slot = count_q - ONE_C;
		unique case (func)
			FN_ADD_FRONT: begin
				is_ins   = 1'b1;
				ins_slot = '0;
			end
			FN_ADD_BACK: begin
				is_ins   = 1'b1;
				ins_slot = count_q;
			end
			FN_INSERT_AT: begin
				is_ins   = 1'b1;
				ins_slot = position;
			end
			FN_DEL_FRONT: begin
				is_del   = 1'b1;
				del_slot = '0;
			end
			FN_DEL_BACK: begin
				is_del   = 1'b1;
				del_slot = count_q - ONE_C;
			end
			FN_DEL_AT: begin
				is_del   = 1'b1;
				del_slot = position;
			end
			default: begin
			end
		endcase

		if (is_ins) begin
			if (count_q == CAP_C) begin
				dec_status = STAT_FULL;
			end else if (ins_slot > count_q) begin
				dec_status = STAT_RANGE;
			end else begin
				dec_status = STAT_OK;
			end
		end else if (is_del) begin
			if (count_q == '0) begin
				dec_status = STAT_EMPTY;
			end else if (del_slot >= count_q) begin
				dec_status = STAT_RANGE;
			end else begin
				dec_status = STAT_OK;
			end
		end else begin
			dec_status = STAT_RANGE;
		end
	end

	// Store port control: a pending element move owns the write port.
	always_comb begin
		mem_we    = wr_pend_s1 || (state_q == ST_PUT);
		mem_waddr = wr_pend_s1 ? wr_addr_s1 : slot_q;
		mem_wdata = wr_pend_s1 ? mem_rdata : value_q;
		mem_re    = (state_q == ST_SHIFT) || (state_q == ST_RD_LAST) ||
		            ((state_q == ST_RD_FIRST) && !wr_pend_s1);
		unique case (state_q)
			ST_RD_FIRST: mem_raddr = '0;
			ST_RD_LAST:  mem_raddr = IDX_W'(count_q - ONE_C);
			default:     mem_raddr = ptr_q;
		endcase
	end

	ple_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Sequencer: shifts the tail one element per cycle, then refreshes the
	// front and back copies and hands the item to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ptr_q         <= '0;
			stop_q        <= '0;
			slot_q        <= '0;
			is_ins_q      <= 1'b0;
			value_q       <= '0;
			count_q       <= '0;
			status_q      <= STAT_OK;
			removed_q     <= '0;
			first_q       <= '0;
			last_q        <= '0;
			wr_pend_s1    <= 1'b0;
			wr_addr_s1    <= '0;
			cap_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
			status_q2_q   <= STAT_OK;
			count_out_q   <= '0;
			removed_out_q <= '0;
			first_out_q   <= '0;
			last_out_q    <= '0;
		end else begin
			// Moves issued by the shift loop land in the cycle after their read.
			wr_pend_s1 <= 1'b0;
			cap_s1     <= 1'b0;
			if (cap_s1) begin
				removed_q <= mem_rdata;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q  <= dec_status;
						removed_q <= '0;
						value_q   <= value;
						is_ins_q  <= is_ins;
						if (dec_status != STAT_OK) begin
							state_q <= ST_FINISH;
						end else if (is_ins) begin
							count_q <= count_q + ONE_C;
							slot_q  <= IDX_W'(ins_slot);
							ptr_q   <= IDX_W'(count_q - ONE_C);
							stop_q  <= IDX_W'(ins_slot);
							state_q <= (ins_slot == count_q) ? ST_PUT : ST_SHIFT;
						end else begin
							count_q <= count_q - ONE_C;
							slot_q  <= IDX_W'(del_slot);
							ptr_q   <= IDX_W'(del_slot);
							stop_q  <= IDX_W'(count_q - ONE_C);
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (is_ins_q) begin
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= ptr_q + IDX_W'(1);
						ptr_q      <= ptr_q - IDX_W'(1);
					end else begin
						wr_pend_s1 <= (ptr_q != slot_q);
						cap_s1     <= (ptr_q == slot_q);
						wr_addr_s1 <= ptr_q - IDX_W'(1);
						ptr_q      <= ptr_q + IDX_W'(1);
					end
					if (ptr_q == stop_q) begin
						state_q <= is_ins_q ? ST_PUT : ST_RD_FIRST;
					end
				end
				ST_PUT: begin
					if (!wr_pend_s1) begin
						state_q <= ST_RD_FIRST;
					end
				end
				ST_RD_FIRST: begin
					if (!wr_pend_s1) begin
						state_q <= ST_RD_LAST;
					end
				end
				ST_RD_LAST: begin
					first_q <= mem_rdata;
					state_q <= ST_GRAB;
				end
				ST_GRAB: begin
					last_q  <= mem_rdata;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_free) begin
						rsp_valid_q   <= 1'b1;
						status_q2_q   <= status_q;
						count_out_q   <= count_q;
						removed_out_q <= removed_q;
						first_out_q   <= (count_q == '0) ? '0 : first_q;
						last_out_q    <= (count_q == '0) ? '0 : last_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q2_q;
	assign count         = count_out_q;
	assign removed_value = removed_out_q;
	assign first_value   = first_out_q;
	assign last_value    = last_out_q;

endmodule

### rtl/core/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port checks for the positional list engine
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = 16,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_stall,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic [STAT_W-1:0]        status,
	input logic [CNT_W-1:0]         count,
	input logic signed [DATA_W-1:0] removed_value,
	input logic signed [DATA_W-1:0] first_value,
	input logic signed [DATA_W-1:0] last_value
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// A stalled result item holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(count) &&
		$stable(removed_value) && $stable(first_value) && $stable(last_value))
		else $error("result item changed while stalled");

	// The engine works on one item at a time and is busy right after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while an item was in progress");

	// A failed operation removes nothing.
	a_error_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> removed_value == '0)
		else $error("failed operation reports a removed value");

	// An empty list reports zero for its front and back.
	a_empty_ends_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (count == '0) |-> (first_value == '0) && (last_value == '0))
		else $error("empty list reports nonzero front or back");

	// The element count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CAP_C)
		else $error("element count above capacity");

endmodule

bind positional_list_engine_top ple_checker #(
	.CAPACITY(CAPACITY)
) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.status        (status),
	.count         (count),
	.removed_value (removed_value),
	.first_value   (first_value),
	.last_value    (last_value)
);
